@@ hdl/hmaf_pkg.sv @@
// Shared types, sizes and the coefficient table for the Henderson moving average filter.
// No dependencies; every other file of the block imports this package.

package hmaf_pkg;

  // Sample and coefficient formats (Q16.16 samples, Q0.16 coefficients)
  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int ROUND_BIAS = 2 ** (FRAC_W - 1);

  // Filter geometry
  localparam int MAX_TAPS   = 13;
  localparam int PERIOD_W   = 4;
  localparam int MIN_PERIOD = 7;
  localparam int MAX_PERIOD = 13;
  localparam int NUM_ROWS   = MAX_PERIOD - MIN_PERIOD + 1;
  localparam int ROW_W      = 3;

  // Adder tree: products are summed in groups, then the groups are summed
  localparam int GROUP_SIZE = 4;
  localparam int NUM_GROUPS = (MAX_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int GSUM_W     = PROD_W + 2;
  localparam int SUM_W      = GSUM_W + 2;
  localparam int ROUND_W    = SUM_W - FRAC_W;

  // Register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD = '0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [GSUM_W-1:0]   gsum_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [PERIOD_W-1:0]        period_t;
  typedef logic [ROW_W-1:0]           row_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic    restart;         // period written this cycle
    period_t restart_period;  // value being written (already clamped)
    period_t period;          // period in use
  } cfg_t;

  // One row per period, oldest tap first, zero-padded at the oldest end
  localparam int COEF_ROWS [NUM_ROWS][MAX_TAPS] = '{
    '{0, 0, 0, 0, 0, 0, -6029, -3801, 786, 7864, 15991, 23134, 27591},
    '{0, 0, 0, 0, 0, -2818, -2490, 131, 5243, 11403, 16646, 19137, 18285},
    '{0, 0, 0, 0, -1049, -1638, 197, 4456, 9765, 14156, 15794, 14156, 9699},
    '{0, 0, 0, -590, -1442, 262, 4325, 9503, 13631, 15073, 13173, 8585, 3015},
    '{0, 0, -721, -1442, 197, 4391, 9503, 13763, 15401, 13435, 8913, 3277, -1180},
    '{0, -1114, -1638, 66, 4325, 9634, 13959, 15598, 13894, 9437, 3998, -393, -2228},
    '{-1245, -1835, 0, 4325, 9634, 14025, 15729, 14025, 9634, 4325, 0, -1835, -1245}
  };

  // Coefficient for delay-line position tap (0 = newest sample)
  function automatic coef_t coef_at(row_t row, int tap);
    row_t r;
    r = (row < ROW_W'(NUM_ROWS)) ? row : ROW_W'(NUM_ROWS - 1);
    return COEF_W'(COEF_ROWS[r][MAX_TAPS-1-tap]);
  endfunction

endpackage

@@ hdl/hmaf_sample_if.sv @@
// Input stream channel of the Henderson moving average filter: valid/ready plus one sample.
// Depends on hmaf_pkg.

interface hmaf_sample_if;
  import hmaf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

@@ hdl/hmaf_filtered_if.sv @@
// Result stream channel of the Henderson moving average filter: valid/ready plus one average.
// Depends on hmaf_pkg.

interface hmaf_filtered_if;
  import hmaf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered;

  modport source(output valid, output filtered, input ready);
  modport sink(input valid, input filtered, output ready);
endinterface

@@ hdl/hmaf_cfg.sv @@
// APB-style register block of the Henderson moving average filter: holds the filter period.
// Depends on hmaf_pkg.

module hmaf_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hmaf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [hmaf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hmaf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output hmaf_pkg::cfg_t                   cfg
);
  import hmaf_pkg::*;

  logic    sel_period;
  logic    wr_period;
  period_t wr_value;
  period_t period;

  assign pready     = 1'b1;
  assign sel_period = (paddr[APB_ADDR_W-1:2] == REG_PERIOD);
  assign wr_period  = psel && penable && pwrite && sel_period;

  // Clamp the written period into the supported range
  always_comb begin
    wr_value = pwdata[PERIOD_W-1:0];
    if (wr_value < PERIOD_W'(MIN_PERIOD)) begin
      wr_value = PERIOD_W'(MIN_PERIOD);
    end else if (wr_value > PERIOD_W'(MAX_PERIOD)) begin
      wr_value = PERIOD_W'(MAX_PERIOD);
    end
  end

  // Hold the period register
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_W'(MAX_PERIOD);
    end else if (wr_period) begin
      period <= wr_value;
    end
  end

  // Read back
  assign prdata = sel_period ? APB_DATA_W'(period) : '0;

  assign cfg.restart        = wr_period;
  assign cfg.restart_period = wr_value;
  assign cfg.period         = period;
endmodule

@@ hdl/hmaf_taps.sv @@
// Delay line and warm-up control of the Henderson moving average filter.
// Depends on hmaf_pkg; feeds hmaf_mac.

module hmaf_taps (
  input  logic                clk,
  input  logic                rst,
  input  hmaf_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  hmaf_pkg::sample_t   in_sample,
  output logic                in_ready,
  output logic                tap_valid,
  output hmaf_pkg::sample_t   taps [hmaf_pkg::MAX_TAPS],
  input  logic                taps_ready
);
  import hmaf_pkg::*;

  period_t warmup_left;
  logic    accept;

  // Take a sample whenever the snapshot is empty or moves on this cycle
  assign in_ready = !tap_valid || taps_ready;
  assign accept   = in_valid && in_ready;

  // Shift the delay line, newest sample at position 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        taps[i] <= '0;
      end
    end else if (accept) begin
      taps[0] <= in_sample;
      for (int i = 1; i < MAX_TAPS; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  // Count down the warm-up; a period write restarts it
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_left <= PERIOD_W'(MAX_PERIOD - 1);
    end else if (cfg.restart) begin
      warmup_left <= cfg.restart_period - PERIOD_W'(1);
    end else if (accept && (warmup_left != '0)) begin
      warmup_left <= warmup_left - PERIOD_W'(1);
    end
  end

  // Mark a snapshot that must produce a result
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
    end else if (accept) begin
      tap_valid <= (warmup_left == '0);
    end else if (taps_ready) begin
      tap_valid <= 1'b0;
    end
  end
endmodule

@@ hdl/hmaf_mac.sv @@
// Multiply and partial-sum stages of the Henderson moving average filter.
// Depends on hmaf_pkg; takes taps from hmaf_taps, feeds hmaf_out.

module hmaf_mac (
  input  logic                clk,
  input  logic                rst,
  input  hmaf_pkg::period_t   period,
  input  logic                tap_valid,
  input  hmaf_pkg::sample_t   taps [hmaf_pkg::MAX_TAPS],
  output logic                taps_ready,
  output logic                gsum_valid,
  output hmaf_pkg::gsum_t     gsums [hmaf_pkg::NUM_GROUPS],
  input  logic                gsum_ready
);
  import hmaf_pkg::*;

  row_t  row;
  logic  prod_valid;
  prod_t prods [MAX_TAPS];
  logic  gsum_load;
  gsum_t gsums_next [NUM_GROUPS];

  assign row        = ROW_W'(period - PERIOD_W'(MIN_PERIOD));
  assign gsum_load  = !gsum_valid || gsum_ready;
  assign taps_ready = !prod_valid || gsum_load;

  // Register one product per tap
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (taps_ready) begin
      prod_valid <= tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (taps_ready) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        prods[i] <= taps[i] * coef_at(row, i);
      end
    end
  end

  // Sum the products in small groups
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gsums_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < MAX_TAPS) begin
          gsums_next[g] = gsums_next[g] + GSUM_W'(prods[g*GROUP_SIZE+k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gsum_valid <= 1'b0;
    end else if (gsum_load) begin
      gsum_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (gsum_load) begin
      gsums <= gsums_next;
    end
  end
endmodule

@@ hdl/hmaf_out.sv @@
// Final sum, rounding, saturation and result register of the Henderson moving average filter.
// Depends on hmaf_pkg; takes group sums from hmaf_mac.

module hmaf_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                gsum_valid,
  input  hmaf_pkg::gsum_t     gsums [hmaf_pkg::NUM_GROUPS],
  output logic                gsum_ready,
  output logic                out_valid,
  output hmaf_pkg::sample_t   out_filtered,
  input  logic                out_ready
);
  import hmaf_pkg::*;

  sum_t                       total;
  logic signed [ROUND_W-1:0]  rounded;
  logic [ROUND_W-SAMPLE_W:0]  top_bits;
  sample_t                    filtered_next;

  assign gsum_ready = !out_valid || out_ready;

  // Add the groups and the rounding bias, drop the fraction, saturate
  always_comb begin
    total = SUM_W'(ROUND_BIAS);
    for (int g = 0; g < NUM_GROUPS; g++) begin
      total = total + SUM_W'(gsums[g]);
    end
    rounded  = total[SUM_W-1:FRAC_W];
    top_bits = rounded[ROUND_W-1:SAMPLE_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      filtered_next = rounded[SAMPLE_W-1:0];
    end else if (rounded[ROUND_W-1]) begin
      filtered_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      filtered_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (gsum_ready) begin
      out_valid <= gsum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (gsum_ready && gsum_valid) begin
      out_filtered <= filtered_next;
    end
  end
endmodule

@@ hdl/henderson_moving_average_filter.sv @@
// Henderson moving average filter: takes one signed Q16.16 sample per clock and returns the
// weighted average of the newest 7 to 13 samples, with the taps set by the period register
// (byte address 0, reset 13, writes clamped to 7..13). A result reaches the output register
// through four register stages (delay line, 13 parallel 32x16 multipliers, group adders,
// final add with round and saturate) that each advance once per clock, so the sustained rate
// is one sample per cycle while the output is taken. After reset or a period write, the first
// period-1 samples only fill the delay line and give no result.
// Write the period only while no sample is in flight.
// Depends on hmaf_pkg, the two stream interfaces and the hmaf_* submodules.

module henderson_moving_average_filter (
  input  logic                             clk,
  input  logic                             rst,
  hmaf_sample_if.sink                      samples,
  hmaf_filtered_if.source                  results,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hmaf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [hmaf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hmaf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import hmaf_pkg::*;

  cfg_t    cfg;
  logic    tap_valid;
  logic    taps_ready;
  sample_t taps [MAX_TAPS];
  logic    gsum_valid;
  logic    gsum_ready;
  gsum_t   gsums [NUM_GROUPS];

  // Period register
  hmaf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Delay line and warm-up
  hmaf_taps u_taps (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (samples.valid),
    .in_sample  (samples.sample),
    .in_ready   (samples.ready),
    .tap_valid  (tap_valid),
    .taps       (taps),
    .taps_ready (taps_ready)
  );

  // Products and group sums
  hmaf_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .period     (cfg.period),
    .tap_valid  (tap_valid),
    .taps       (taps),
    .taps_ready (taps_ready),
    .gsum_valid (gsum_valid),
    .gsums      (gsums),
    .gsum_ready (gsum_ready)
  );

  // Round, saturate and present the result
  hmaf_out u_out (
    .clk          (clk),
    .rst          (rst),
    .gsum_valid   (gsum_valid),
    .gsums        (gsums),
    .gsum_ready   (gsum_ready),
    .out_valid    (results.valid),
    .out_filtered (results.filtered),
    .out_ready    (results.ready)
  );
endmodule

@@ tb/henderson_moving_average_filter_tb.sv @@
// Self-checking testbench for the Henderson moving average filter: directed rows, then
// random sample streams under changing idle patterns and period settings, with a predictor.
// Depends on hmaf_pkg, hmaf_sample_if, hmaf_filtered_if and henderson_moving_average_filter.

module henderson_moving_average_filter_tb;
  import hmaf_pkg::sample_t;
  import hmaf_pkg::APB_ADDR_W;
  import hmaf_pkg::APB_DATA_W;

  localparam int TAPS           = 13;
  localparam int SHORTEST       = 7;
  localparam int LONGEST        = 13;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int ITEMS_PER_SEG  = 94;
  localparam int NUM_SEGS       = 12;
  localparam int MAX_REPORTS    = 10;

  localparam sample_t MAXV = 32'sh7FFF_FFFF;
  localparam sample_t MINV = 32'sh8000_0000;

  localparam logic [APB_ADDR_W-1:0] PERIOD_ADDR = {hmaf_pkg::REG_PERIOD, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR  = {~hmaf_pkg::REG_PERIOD, 2'b00};

  // Q0.16 weights per period (7..13), oldest tap first, zero-padded at the oldest end
  localparam int WEIGHTS [7][TAPS] = '{
    '{0, 0, 0, 0, 0, 0, -6029, -3801, 786, 7864, 15991, 23134, 27591},
    '{0, 0, 0, 0, 0, -2818, -2490, 131, 5243, 11403, 16646, 19137, 18285},
    '{0, 0, 0, 0, -1049, -1638, 197, 4456, 9765, 14156, 15794, 14156, 9699},
    '{0, 0, 0, -590, -1442, 262, 4325, 9503, 13631, 15073, 13173, 8585, 3015},
    '{0, 0, -721, -1442, 197, 4391, 9503, 13763, 15401, 13435, 8913, 3277, -1180},
    '{0, -1114, -1638, 66, 4325, 9634, 13959, 15598, 13894, 9437, 3998, -393, -2228},
    '{-1245, -1835, 0, 4325, 9634, 14025, 15729, 14025, 9634, 4325, 0, -1835, -1245}
  };

  typedef enum logic {ROW_SAMPLE, ROW_SET_PERIOD} row_op_t;
  typedef enum logic [1:0] {OUT_NONE, OUT_PREDICT, OUT_TYPED} row_out_t;

  typedef struct {
    row_op_t     op;
    logic [31:0] value;
    row_out_t    out;
    sample_t     typed;
  } stim_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  hmaf_sample_if   smp_ch();
  hmaf_filtered_if flt_ch();

  henderson_moving_average_filter u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (smp_ch),
    .results (flt_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: delay line (newest at 0), period in use, samples left to swallow
  sample_t     history [TAPS];
  int unsigned taps_in_use;
  int unsigned warm_left;

  sample_t   filtered_pending [$];
  stim_row_t directed_rows [$];
  int        fails;
  int        src_idle_pct;
  int        snk_idle_pct;
  bit        holdoff_armed;
  int        run_left;
  sample_t   run_value;
  int        idle_cycles;

  // Shift one sample in and compute the saturated, rounded weighted sum
  function automatic bit filter_step(input sample_t s, output sample_t y);
    longint acc;
    longint rounded;
    int     r;
    for (int i = TAPS - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = s;
    y = '0;
    if (warm_left != 0) begin
      warm_left--;
      return 1'b0;
    end
    r = taps_in_use - SHORTEST;
    acc = 0;
    for (int i = 0; i < TAPS; i++)
      acc += longint'(history[i]) * longint'(WEIGHTS[r][TAPS-1-i]);
    // Halves round toward plus infinity
    rounded = (acc + 64'sd32768) >>> 16;
    if (rounded > longint'(MAXV)) rounded = longint'(MAXV);
    if (rounded < longint'(MINV)) rounded = longint'(MINV);
    y = sample_t'(rounded);
    return 1'b1;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    fails++;
    if (fails <= MAX_REPORTS)
      $display("MISMATCH %s: expected %h, got %h", what, want, got);
  endfunction

  function automatic void add_row(row_op_t op, logic [31:0] value, row_out_t out,
                                  sample_t typed);
    stim_row_t row;
    row.op    = op;
    row.value = value;
    row.out   = out;
    row.typed = typed;
    directed_rows.push_back(row);
  endfunction

  // Mix of full-range noise, full-scale extremes, small values, half-LSB values and runs of one value
  function automatic sample_t next_sample();
    if (run_left != 0) begin
      run_left--;
      return run_value;
    end
    unique case ($urandom_range(19))
      0: begin
        run_left  = $urandom_range(16, 12);
        run_value = ($urandom_range(2) == 0) ? sample_t'($urandom())
                  : ($urandom_range(1) ? MAXV : MINV);
        return run_value;
      end
      1: return MAXV;
      2: return MINV;
      3, 4, 5: return sample_t'(int'($urandom_range(262143)) - 131072);
      6: return $urandom_range(1) ? 32'sh0000_8000 : 32'shFFFF_8000;
      default: return sample_t'($urandom());
    endcase
  endfunction

  // One APB transaction: setup cycle, then access until pready
  task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                          input logic [31:0] wd, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_period();
    logic [31:0] rd;
    apb_xfer(1'b0, PERIOD_ADDR, '0, rd);
    if (rd !== 32'(taps_in_use)) note_mismatch("period readback", 32'(taps_in_use), rd);
  endtask

  // Write the period with random upper bits, mirror the clamp, read it back
  task automatic program_period(input logic [3:0] p);
    logic [31:0] wd;
    logic [31:0] rd;
    wd = $urandom();
    wd[3:0] = p;
    apb_xfer(1'b1, PERIOD_ADDR, wd, rd);
    taps_in_use = (p < SHORTEST) ? SHORTEST : (p > LONGEST) ? LONGEST : p;
    warm_left   = taps_in_use - 1;
    check_period();
  endtask

  // Stop offering, wait for every pending result, then let the pipeline settle
  task automatic drain_results();
    smp_ch.valid <= 1'b0;
    while (filtered_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one sample until a transaction completes, then record what it should produce
  task automatic push_sample(input sample_t v, input row_out_t out, input sample_t typed);
    sample_t y;
    bit      got;
    while ($urandom_range(99) < src_idle_pct) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.valid  <= 1'b1;
    smp_ch.sample <= v;
    do @(posedge clk); while (!smp_ch.ready);
    got = filter_step(v, y);
    if (out == OUT_TYPED) filtered_pending.push_back(typed);
    else if (out == OUT_PREDICT && got) filtered_pending.push_back(y);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off when armed
  initial begin
    flt_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_armed) begin
        holdoff_armed = 1'b0;
        flt_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else begin
        flt_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Compare each result transaction with the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && flt_ch.valid && flt_ch.ready) begin
      if (filtered_pending.size() == 0)
        note_mismatch("result with nothing pending", 'x, flt_ch.filtered);
      else if (flt_ch.filtered !== filtered_pending[0])
        note_mismatch("filtered", filtered_pending.pop_front(), flt_ch.filtered);
      else
        void'(filtered_pending.pop_front());
    end
  end

  // Watchdog: end the run when no transaction completes for too long
  always @(posedge clk) begin
    if ((smp_ch.valid && smp_ch.ready) || (flt_ch.valid && flt_ch.ready) ||
        (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("henderson_moving_average_filter verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    logic [31:0] rd;
    logic [3:0]  period_plan [NUM_SEGS];
    int          k;

    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    smp_ch.valid  = 1'b0;
    smp_ch.sample = '0;
    fails         = 0;
    idle_cycles   = 0;
    run_left      = 0;
    run_value     = '0;
    holdoff_armed = 1'b0;
    src_idle_pct  = 7;
    snk_idle_pct  = 57;
    foreach (history[i]) history[i] = '0;
    taps_in_use = LONGEST;
    warm_left   = LONGEST - 1;
    period_plan = '{4'd0, 4'd13, 4'd15, 4'd9, 4'd3, 4'd11, 4'd7, 4'd14, 4'd8, 4'd10,
                    4'd12, 4'd5};

    // Period 13 after reset: warm-up on full scale, then saturation high
    repeat (12) add_row(ROW_SAMPLE, MAXV, OUT_NONE, '0);
    add_row(ROW_SAMPLE, MAXV, OUT_TYPED, MAXV);
    // Period 7: weights sum to one, so a full line of the minimum passes unchanged
    add_row(ROW_SET_PERIOD, 32'd7, OUT_NONE, '0);
    repeat (6) add_row(ROW_SAMPLE, MINV, OUT_NONE, '0);
    add_row(ROW_SAMPLE, MINV, OUT_TYPED, MINV);
    // Flush with zeros, then half-LSB ties that round up
    repeat (6) add_row(ROW_SAMPLE, 32'h0, OUT_PREDICT, '0);
    add_row(ROW_SAMPLE, 32'h0000_8000, OUT_TYPED, 32'sd13796);
    add_row(ROW_SAMPLE, 32'hFFFF_8000, OUT_TYPED, -32'sd2228);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    check_period();

    // Walk the directed rows
    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      if (row.op == ROW_SET_PERIOD) begin
        drain_results();
        program_period(row.value[3:0]);
      end else begin
        push_sample(sample_t'(row.value), row.out, row.typed);
      end
    end

    // Random segments: three idle patterns, a period write for each segment
    for (k = 0; k < NUM_SEGS; k++) begin
      drain_results();
      if (k == 4) begin
        src_idle_pct = 57;
        snk_idle_pct = 7;
      end else if (k == 8) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      program_period(period_plan[k]);
      // A write to the unused register must leave the period and warm-up alone
      if (k == 5) begin
        apb_xfer(1'b1, SPARE_ADDR, $urandom(), rd);
        check_period();
      end
      if (k == 9) holdoff_armed = 1'b1;
      repeat (ITEMS_PER_SEG) push_sample(next_sample(), OUT_PREDICT, '0);
    end

    drain_results();
    if (fails == 0 && filtered_pending.size() == 0)
      $display("henderson_moving_average_filter verification clean");
    else
      $display("henderson_moving_average_filter verification failed");
    $finish;
  end

endmodule
